[hw/rtl/heartbeat_failure_detector_macros.svh]
`ifndef HEARTBEAT_FAILURE_DETECTOR_MACROS_SVH
`define HEARTBEAT_FAILURE_DETECTOR_MACROS_SVH

// same-cycle implication
`define HBFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbfd assertion failed");

// next-cycle implication
`define HBFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbfd assertion failed");

`endif

[hw/rtl/hbfd_pkg.sv]
`default_nettype none
package hbfd_pkg;

   localparam int KIND_W     = 2;
   localparam int PEER_W     = 5;
   localparam int ACTION_W   = 2;
   localparam int PERIOD_W   = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALIVE     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK      = 2'd2;

   localparam logic [ACTION_W-1:0] ACT_HEARTBEAT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ALIVE     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SUSPECT   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_RESTORE   = 2'd3;

   localparam logic [REG_IDX_W-1:0] REG_OWN_RANK     = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_HIGHEST_RANK = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_CHECK_PERIOD = 2'd2;

   localparam logic [PEER_W-1:0]   OWN_RANK_RST     = 5'd1;
   localparam logic [PEER_W-1:0]   HIGHEST_RANK_RST = 5'd16;
   localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = 8'd4;

   typedef struct packed {
      logic [PEER_W-1:0]   own_rank;
      logic [PEER_W-1:0]   highest_rank;
      logic [PERIOD_W-1:0] check_period;
   } cfg_type;

   typedef struct packed {
      logic slot_free;
      logic start_walk;
      logic walk_last_step;
   } status_type;

   typedef struct packed {
      logic accept;
      logic step;
   } cmd_type;

endpackage
`default_nettype wire

[hw/rtl/hbfd_req_if.sv]
`default_nettype none
interface hbfd_req_if;
   import hbfd_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [PEER_W-1:0] sender;

   modport source (output valid, output kind, output sender, input ready);
   modport sink   (input valid, input kind, input sender, output ready);
endinterface
`default_nettype wire

[hw/rtl/hbfd_rsp_if.sv]
`default_nettype none
interface hbfd_rsp_if;
   import hbfd_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PEER_W-1:0]   peer;
   logic                last;

   modport source (output valid, output action, output peer, output last, input ready);
   modport sink   (input valid, input action, input peer, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/hbfd_csr.sv]
`default_nettype none
module hbfd_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [hbfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [hbfd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [hbfd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                            csr_pready,
   output      hbfd_pkg::cfg_type               cfg
);
   import hbfd_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_OWN_RANK:     cfg_in.own_rank     = csr_pwdata[PEER_W-1:0];
            REG_HIGHEST_RANK: cfg_in.highest_rank = csr_pwdata[PEER_W-1:0];
            REG_CHECK_PERIOD: cfg_in.check_period = csr_pwdata[PERIOD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OWN_RANK:     csr_prdata = CSR_DATA_W'(cfg_ff.own_rank);
         REG_HIGHEST_RANK: csr_prdata = CSR_DATA_W'(cfg_ff.highest_rank);
         REG_CHECK_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.check_period);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_rank     <= OWN_RANK_RST;
         cfg_ff.highest_rank <= HIGHEST_RANK_RST;
         cfg_ff.check_period <= CHECK_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/hbfd_ctrl.sv]
`default_nettype none
module hbfd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire hbfd_pkg::status_type status,
   output      hbfd_pkg::cmd_type    cmd
);
   import hbfd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.step   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = status.slot_free;
            cmd.accept = req_valid && status.slot_free;
            if (cmd.accept && status.start_walk) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = status.slot_free;
            if (cmd.step && status.walk_last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/hbfd_dp.sv]
`default_nettype none
`include "heartbeat_failure_detector_macros.svh"
module hbfd_dp #(
   parameter int RANK_CAP = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hbfd_pkg::cfg_type             cfg,
   input  wire hbfd_pkg::cmd_type             cmd,
   output      hbfd_pkg::status_type          status,
   input  wire logic                          req_valid,
   input  wire logic [hbfd_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [hbfd_pkg::PEER_W-1:0]   req_sender,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [hbfd_pkg::ACTION_W-1:0] rsp_action,
   output      logic [hbfd_pkg::PEER_W-1:0]   rsp_peer,
   output      logic                          rsp_last
);
   import hbfd_pkg::*;

   localparam int RANK_W = $clog2(RANK_CAP + 1);
   localparam int MARK_W = RANK_CAP + 1;
   localparam logic [PEER_W-1:0] MAX_PEER = PEER_W'(RANK_CAP);

   logic [MARK_W-1:0]   alive_ff, alive_in;
   logic [MARK_W-1:0]   suspect_ff, suspect_in;
   logic [PERIOD_W-1:0] tick_ff, tick_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [PEER_W-1:0]   peer_ff, peer_in;
   logic                last_ff, last_in;

   logic [RANK_W-1:0]   top_rank;
   logic [RANK_W-1:0]   self_rank;
   logic [RANK_W-1:0]   sender_idx;
   logic [PERIOD_W:0]   tick_sum;
   logic                check_hit;
   logic                need_ind;
   logic                hb_last;
   logic                slot_free;
   logic                alive_wr;

   assign top_rank   = (cfg.highest_rank > MAX_PEER) ? RANK_W'(RANK_CAP)
                                                     : cfg.highest_rank[RANK_W-1:0];
   assign self_rank  = (cfg.own_rank == '0)      ? RANK_W'(1) :
                       (cfg.own_rank > MAX_PEER) ? RANK_W'(RANK_CAP)
                                                 : cfg.own_rank[RANK_W-1:0];
   assign sender_idx = req_sender[RANK_W-1:0];
   assign tick_sum   = {1'b0, tick_ff} + (PERIOD_W+1)'(1);
   assign check_hit  = tick_sum >= {1'b0, cfg.check_period};
   assign need_ind   = alive_ff[rank_ff] == suspect_ff[rank_ff];
   assign hb_last    = (rank_ff == top_rank) ||
                       ((rank_ff + RANK_W'(1) == top_rank) && (self_rank == top_rank));
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign alive_wr   = cmd.accept && (req_kind == KIND_ALIVE) && (req_sender <= MAX_PEER);

   assign status.slot_free      = slot_free;
   assign status.start_walk     = req_valid && (req_kind == KIND_TICK) && check_hit;
   assign status.walk_last_step = (top_rank == '0) ||
                                  ((rank_ff == top_rank) &&
                                   ((rank_ff == self_rank) || !need_ind));

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = action_ff;
   assign rsp_peer   = peer_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      alive_in     = alive_ff;
      suspect_in   = suspect_ff;
      tick_in      = tick_ff;
      rank_in      = rank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      action_in    = action_ff;
      peer_in      = peer_ff;
      last_in      = last_ff;

      if (cmd.accept) begin
         case (req_kind)
            KIND_HEARTBEAT: begin
               rsp_valid_in = 1'b1;
               action_in    = ACT_ALIVE;
               peer_in      = req_sender;
               last_in      = 1'b1;
            end
            KIND_ALIVE: begin
               if (req_sender <= MAX_PEER) begin
                  alive_in[sender_idx] = 1'b1;
               end
            end
            KIND_TICK: begin
               if (check_hit) begin
                  tick_in = '0;
                  rank_in = RANK_W'(1);
               end else begin
                  tick_in = tick_sum[PERIOD_W-1:0];
               end
            end
            default: ;
         endcase
      end

      if (cmd.step) begin
         if (top_rank == '0) begin
            alive_in = '0;
         end else if (rank_ff == self_rank) begin
            rank_in = rank_ff + RANK_W'(1);
            if (rank_ff == top_rank) begin
               alive_in = '0;
            end
         end else if (need_ind) begin
            suspect_in[rank_ff] = !suspect_ff[rank_ff];
            rsp_valid_in        = 1'b1;
            action_in           = alive_ff[rank_ff] ? ACT_RESTORE : ACT_SUSPECT;
            peer_in             = PEER_W'(rank_ff);
            last_in             = 1'b0;
         end else begin
            rsp_valid_in = 1'b1;
            action_in    = ACT_HEARTBEAT;
            peer_in      = PEER_W'(rank_ff);
            last_in      = hb_last;
            rank_in      = rank_ff + RANK_W'(1);
            if (rank_ff == top_rank) begin
               alive_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff     <= '1;
         suspect_ff   <= '0;
         tick_ff      <= '0;
         rank_ff      <= RANK_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         alive_ff     <= alive_in;
         suspect_ff   <= suspect_in;
         tick_ff      <= tick_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      peer_ff   <= peer_in;
      last_ff   <= last_in;
   end

   `HBFD_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.accept, cmd.step}))
   `HBFD_ASSERT_IMP(a_step_free, clock, reset, cmd.step, slot_free)
   `HBFD_ASSERT_NXT(a_alive_set, clock, reset, alive_wr, alive_ff[$past(sender_idx)])
   `HBFD_ASSERT_NXT(a_tick_restart, clock, reset, cmd.accept && status.start_walk, tick_ff == '0)

endmodule
`default_nettype wire

[hw/rtl/heartbeat_failure_detector.sv]
// Heartbeat/alive-reply/unknown transactions: result (if any) registered in the cycle after accept.
// Tick without a check: tick count only. Tick with a check: the controller's rank walk emits
// each result or skips the own rank, and no request is accepted until the walk ends.
// Results drain through a single output register; a full, stalled register stalls the walk.
// Reset (synchronous, active high): all peers alive, none suspected, tick count zero,
// registers own_rank=1, highest_rank=16, check_period=4.
`default_nettype none
module heartbeat_failure_detector #(
   parameter int RANK_CAP = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   hbfd_req_if.sink                             req,
   hbfd_rsp_if.source                           rsp,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [hbfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [hbfd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [hbfd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                            csr_pready
);
   import hbfd_pkg::*;

   cfg_type    cfg;
   status_type status;
   cmd_type    cmd;

   hbfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hbfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hbfd_dp #(
      .RANK_CAP (RANK_CAP)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_valid  (req.valid),
      .req_kind   (req.kind),
      .req_sender (req.sender),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_action (rsp.action),
      .rsp_peer   (rsp.peer),
      .rsp_last   (rsp.last)
   );

endmodule
`default_nettype wire

[tb/hbfd_checker.sv]
module hbfd_checker
   import hbfd_pkg::*;
#(
   parameter int RANK_CAP = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [PEER_W-1:0]     req_sender,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [ACTION_W-1:0]   rsp_action,
   input  logic [PEER_W-1:0]     rsp_peer,
   input  logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PEER_W-1:0]   peer;
      logic                last;
   } peer_action_type;

   peer_action_type     expected_actions[$];

   logic [PEER_W-1:0]   own_rank;
   logic [PEER_W-1:0]   highest_rank;
   logic [PERIOD_W-1:0] check_period;
   logic [RANK_CAP:0]   alive_marks;
   logic [RANK_CAP:0]   suspect_marks;
   logic [PERIOD_W-1:0] tick_count;

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void queue_action(input logic [ACTION_W-1:0] action,
                                        input logic [PEER_W-1:0] peer);
      peer_action_type item;
      item.action = action;
      item.peer   = peer;
      item.last   = 1'b0;
      expected_actions.push_back(item);
   endfunction

   function automatic void run_health_check();
      int top_rank;
      int self_rank;
      top_rank  = (highest_rank > RANK_CAP) ? RANK_CAP : int'(highest_rank);
      self_rank = (own_rank == 0) ? 1 :
                  ((own_rank > RANK_CAP) ? RANK_CAP : int'(own_rank));
      for (int r = 1; r <= top_rank; r++) begin
         if (r != self_rank) begin
            if (!alive_marks[r] && !suspect_marks[r]) begin
               suspect_marks[r] = 1'b1;
               queue_action(ACT_SUSPECT, PEER_W'(r));
            end else if (alive_marks[r] && suspect_marks[r]) begin
               suspect_marks[r] = 1'b0;
               queue_action(ACT_RESTORE, PEER_W'(r));
            end
            queue_action(ACT_HEARTBEAT, PEER_W'(r));
         end
      end
      alive_marks = '0;
   endfunction

   function automatic void predict_message(input logic [KIND_W-1:0] kind,
                                           input logic [PEER_W-1:0] sender);
      int queued;
      int next_count;
      queued = expected_actions.size();
      case (kind)
         KIND_HEARTBEAT: queue_action(ACT_ALIVE, sender);
         KIND_ALIVE: begin
            if (sender <= RANK_CAP) alive_marks[sender] = 1'b1;
         end
         KIND_TICK: begin
            next_count = int'(tick_count) + 1;
            if (next_count >= int'(check_period)) begin
               tick_count = '0;
               run_health_check();
            end else begin
               tick_count = PERIOD_W'(next_count);
            end
         end
         default: ;
      endcase
      if (expected_actions.size() > queued)
         expected_actions[expected_actions.size()-1].last = 1'b1;
   endfunction

   task automatic compare_action();
      peer_action_type want;
      if (expected_actions.size() == 0) begin
         report_mismatch($sformatf("unexpected transaction action %0d peer %0d last %0d",
                                   rsp_action, rsp_peer, rsp_last));
         return;
      end
      want = expected_actions.pop_front();
      if (rsp_action !== want.action)
         report_mismatch($sformatf("action %0d, expected %0d (peer %0d)",
                                   rsp_action, want.action, want.peer));
      if (rsp_peer !== want.peer)
         report_mismatch($sformatf("peer %0d, expected %0d", rsp_peer, want.peer));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last %0d, expected %0d (peer %0d)",
                                   rsp_last, want.last, want.peer));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         own_rank      = OWN_RANK_RST;
         highest_rank  = HIGHEST_RANK_RST;
         check_period  = CHECK_PERIOD_RST;
         alive_marks   = '1;
         suspect_marks = '0;
         tick_count    = '0;
         fail_count    = 0;
         expected_actions.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_action();
         if (req_valid && req_ready) predict_message(req_kind, req_sender);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_OWN_RANK:     own_rank     = csr_pwdata[PEER_W-1:0];
               REG_HIGHEST_RANK: highest_rank = csr_pwdata[PEER_W-1:0];
               REG_CHECK_PERIOD: check_period = csr_pwdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_actions.size();
   end

endmodule

[tb/tb_heartbeat_failure_detector.sv]
module tb_heartbeat_failure_detector;
   import hbfd_pkg::*;

   localparam int RANK_CAP = 16;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 32;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;
   bit                    quiet;

   int own_set[8]     = '{1, 16, 0, 31, 17, 5, 2, 9};
   int highest_set[8] = '{16, 16, 17, 31, 31, 1, 0, 2};
   int period_set[8]  = '{4, 1, 3, 255, 2, 0, 6, 5};

   hbfd_req_if req_ch();
   hbfd_rsp_if rsp_ch();

   heartbeat_failure_detector #(.RANK_CAP(RANK_CAP)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   hbfd_checker #(.RANK_CAP(RANK_CAP)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_kind    (req_ch.kind),
      .req_sender  (req_ch.sender),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_action  (rsp_ch.action),
      .rsp_peer    (rsp_ch.peer),
      .rsp_last    (rsp_ch.last),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 21);
      end
   end

   task automatic send_msg(input logic [KIND_W-1:0] kind, input logic [PEER_W-1:0] sender);
      if (!quiet && $urandom_range(99) < 21) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= kind;
      req_ch.sender <= sender;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // counts only transactions that the block acts on
   task automatic send_random(output bit counted);
      int pick;
      logic [KIND_W-1:0] kind;
      logic [PEER_W-1:0] sender;
      pick    = $urandom_range(99);
      counted = 1'b1;
      if (pick < 35) begin
         kind   = KIND_TICK;
         sender = PEER_W'($urandom);
      end else if (pick < 68) begin
         kind   = KIND_ALIVE;
         sender = PEER_W'($urandom_range(1, RANK_CAP));
      end else if (pick < 90) begin
         kind   = KIND_HEARTBEAT;
         sender = PEER_W'($urandom_range(0, 31));
      end else if (pick < 95) begin
         kind    = KIND_UNKNOWN;
         sender  = PEER_W'($urandom);
         counted = 1'b0;
      end else begin
         kind    = KIND_ALIVE;
         sender  = PEER_W'($urandom_range(RANK_CAP + 1, 31));
         counted = 1'b0;
      end
      send_msg(kind, sender);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int done;
      bit counted;
      quiet          <= 1'b0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= KIND_HEARTBEAT;
      req_ch.sender  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: heartbeats from edge ranks, ignored messages
      send_msg(KIND_HEARTBEAT, 5'd0);
      send_msg(KIND_HEARTBEAT, 5'd16);
      send_msg(KIND_HEARTBEAT, 5'd31);
      send_msg(KIND_ALIVE, 5'd31);
      send_msg(KIND_ALIVE, 5'd17);
      send_msg(KIND_UNKNOWN, 5'd31);
      // all peers alive after reset: plain heartbeat round
      repeat (4) send_msg(KIND_TICK, 5'd0);
      // nobody replied: every peer suspected
      repeat (4) send_msg(KIND_TICK, 5'd31);
      send_msg(KIND_ALIVE, 5'd2);
      send_msg(KIND_ALIVE, 5'd5);
      send_msg(KIND_ALIVE, 5'd16);
      // those three restored
      repeat (4) send_msg(KIND_TICK, 5'd0);

      for (int p = 0; p < 8; p++) begin
         settle();
         write_reg(REG_OWN_RANK, own_set[p]);
         write_reg(REG_HIGHEST_RANK, highest_set[p]);
         write_reg(REG_CHECK_PERIOD, period_set[p]);
         quiet <= (p == 1);
         done = 0;
         while (done < PHASE_ITEMS) begin
            send_random(counted);
            if (counted) done++;
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[heartbeat_failure_detector.f]
+incdir+hw/rtl
hw/rtl/hbfd_pkg.sv
hw/rtl/hbfd_req_if.sv
hw/rtl/hbfd_rsp_if.sv
hw/rtl/hbfd_csr.sv
hw/rtl/hbfd_ctrl.sv
hw/rtl/hbfd_dp.sv
hw/rtl/heartbeat_failure_detector.sv
tb/hbfd_checker.sv
tb/tb_heartbeat_failure_detector.sv
